/* hw/rtl/knap_pkg.sv */
// Shared types and constants for the weight-indexed knapsack core.
`default_nettype none

package knap_pkg;

    // Number of capacity entries held in the table.
    localparam int CAP_ENTRIES = 4096;
    localparam int ADDR_W      = $clog2(CAP_ENTRIES);

    localparam int VALUE_W  = 32;
    localparam int WEIGHT_W = 16;
    localparam int CAP_W    = 12;
    localparam int ENTRY_W  = 48;

    localparam logic [ENTRY_W-1:0] ENTRY_MAX = {ENTRY_W{1'b1}};
    localparam logic [ADDR_W-1:0]  ADDR_TOP  = ADDR_W'(CAP_ENTRIES - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_READ,
        ST_CAPTURE,
        ST_CLEAR
    } state_t;

    // Control from the sequencer to the table, the update unit and the result logic.
    typedef struct packed {
        logic              accept;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr_a;
        logic [ADDR_W-1:0] rd_addr_b;
        logic              wr_en;
        logic              wr_zero;
        logic [ADDR_W-1:0] wr_addr;
        logic              upd_valid;
        logic              load_result;
    } ctrl_t;

endpackage

`default_nettype wire

/* hw/rtl/knap_table.sv */
// Best-value table: one write port and two registered read ports.
`default_nettype none

module knap_table (
    input  wire logic                          clk,
    input  wire logic                          wr_en,
    input  wire logic [knap_pkg::ADDR_W-1:0]   wr_addr,
    input  wire logic [knap_pkg::ENTRY_W-1:0]  wr_data,
    input  wire logic                          rd_en,
    input  wire logic [knap_pkg::ADDR_W-1:0]   rd_addr_a,
    input  wire logic [knap_pkg::ADDR_W-1:0]   rd_addr_b,
    output logic      [knap_pkg::ENTRY_W-1:0]  rd_data_a,
    output logic      [knap_pkg::ENTRY_W-1:0]  rd_data_b
);

    logic [knap_pkg::ENTRY_W-1:0] mem [knap_pkg::CAP_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/knap_update.sv */
// Shared update unit: saturating add of the item value and keep-the-larger compare.
`default_nettype none

module knap_update (
    input  wire logic [knap_pkg::ENTRY_W-1:0] old_entry,
    input  wire logic [knap_pkg::ENTRY_W-1:0] src_entry,
    input  wire logic [knap_pkg::VALUE_W-1:0] item_value,
    output logic      [knap_pkg::ENTRY_W-1:0] new_entry,
    output logic                              sat
);

    logic [knap_pkg::ENTRY_W:0]   sum;
    logic [knap_pkg::ENTRY_W-1:0] cand;

    always_comb
    begin
        sum = {1'b0, src_entry} + (knap_pkg::ENTRY_W + 1)'(item_value);
        // A carry out means the sum passed the largest entry value.
        sat = sum[knap_pkg::ENTRY_W];
        cand = sat ? knap_pkg::ENTRY_MAX : sum[knap_pkg::ENTRY_W-1:0];
        new_entry = (cand > old_entry) ? cand : old_entry;
    end

endmodule

`default_nettype wire

/* hw/rtl/knap_ctrl.sv */
// Sequencer: walks the table for each item, reads the result and clears the table.
`default_nettype none

module knap_ctrl (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           item_valid,
    input  wire logic [knap_pkg::WEIGHT_W-1:0]  item_weight,
    input  wire logic                           last_item,
    input  wire logic [knap_pkg::CAP_W-1:0]     capacity,
    input  wire logic                           slot_free,
    output logic                                item_stall,
    output knap_pkg::ctrl_t                     ctl
);

    knap_pkg::state_t              state_reg, state_next;
    logic [knap_pkg::ADDR_W-1:0]   addr_reg, addr_next;
    logic [knap_pkg::ADDR_W-1:0]   weight_reg, weight_next;
    logic                          last_reg, last_next;
    logic                          s1_valid_reg, s1_valid_next;
    logic [knap_pkg::ADDR_W-1:0]   s1_addr_reg, s1_addr_next;
    logic                          accept;
    logic                          fits;
    logic [knap_pkg::ADDR_W-1:0]   cap_idx;

    assign accept = (state_reg == knap_pkg::ST_IDLE) && item_valid;
    assign fits   = {16'd0, item_weight} < 32'(knap_pkg::CAP_ENTRIES);

    // Capacities past the table read the top entry.
    assign cap_idx = ({20'd0, capacity} >= 32'(knap_pkg::CAP_ENTRIES)) ?
                     knap_pkg::ADDR_TOP : knap_pkg::ADDR_W'(capacity);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= knap_pkg::ST_CLEAR;
            addr_reg     <= knap_pkg::ADDR_TOP;
            s1_valid_reg <= 1'b0;
            last_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            addr_reg     <= addr_next;
            s1_valid_reg <= s1_valid_next;
            last_reg     <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        weight_reg  <= weight_next;
        s1_addr_reg <= s1_addr_next;
    end

    // Next state and counters.
    always_comb
    begin
        state_next    = state_reg;
        addr_next     = addr_reg;
        weight_next   = weight_reg;
        last_next     = last_reg;
        s1_valid_next = (state_reg == knap_pkg::ST_SWEEP);
        s1_addr_next  = addr_reg;
        unique case (state_reg)
            knap_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    last_next   = last_item;
                    weight_next = knap_pkg::ADDR_W'(item_weight);
                    addr_next   = knap_pkg::ADDR_TOP;
                    if (fits)
                    begin
                        state_next = knap_pkg::ST_SWEEP;
                    end
                    else if (last_item)
                    begin
                        state_next = knap_pkg::ST_READ;
                    end
                end
            end
            knap_pkg::ST_SWEEP:
            begin
                if (addr_reg == weight_reg)
                begin
                    state_next = knap_pkg::ST_DRAIN;
                end
                else
                begin
                    addr_next = addr_reg - 1'b1;
                end
            end
            knap_pkg::ST_DRAIN:
            begin
                state_next = last_reg ? knap_pkg::ST_READ : knap_pkg::ST_IDLE;
            end
            knap_pkg::ST_READ:
            begin
                state_next = knap_pkg::ST_CAPTURE;
            end
            knap_pkg::ST_CAPTURE:
            begin
                if (slot_free)
                begin
                    state_next = knap_pkg::ST_CLEAR;
                    addr_next  = knap_pkg::ADDR_TOP;
                end
            end
            knap_pkg::ST_CLEAR:
            begin
                if (addr_reg == '0)
                begin
                    state_next = knap_pkg::ST_IDLE;
                end
                else
                begin
                    addr_next = addr_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = knap_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        item_stall      = (state_reg != knap_pkg::ST_IDLE);
        ctl.accept      = accept;
        ctl.rd_en       = (state_reg == knap_pkg::ST_SWEEP) || (state_reg == knap_pkg::ST_READ);
        ctl.rd_addr_a   = (state_reg == knap_pkg::ST_SWEEP) ? addr_reg : cap_idx;
        ctl.rd_addr_b   = addr_reg - weight_reg;
        ctl.wr_zero     = (state_reg == knap_pkg::ST_CLEAR);
        ctl.wr_en       = s1_valid_reg || (state_reg == knap_pkg::ST_CLEAR);
        ctl.wr_addr     = (state_reg == knap_pkg::ST_CLEAR) ? addr_reg : s1_addr_reg;
        ctl.upd_valid   = s1_valid_reg;
        ctl.load_result = (state_reg == knap_pkg::ST_CAPTURE) && slot_free;
    end

endmodule

`default_nettype wire

/* hw/rtl/knapsack_by_weight_dp_core.sv */
// Top level of the weight-indexed zero-one knapsack core.
//
// Items enter on the item channel (item_value, item_weight, last_item) with
// item_valid and item_stall; a request is taken at a clock edge where
// item_valid is high and item_stall is low. Results leave on the result
// channel (best_value, saturated) under result_valid and result_stall.
// cfg_ready is always high. The user must write the capacity register
// (cfg_valid/cfg_data) only while the block is idle; it does not check this.
//
// An item of weight w below the table size walks the table from the top
// entry down to entry w, one entry per cycle through the shared update unit.
// A heavier item leaves the table unchanged. An item marked last then reads
// the entry at the capacity, places the result in the output register and
// clears the table, one entry per cycle. The single table write port sets
// this pace. After reset the table is cleared in the same way before
// item_stall drops. A stalled result stays in the output register; the
// block waits for that register to be free (empty or being drained) before
// loading a new result and clearing the table.
`default_nettype none

module knapsack_by_weight_dp_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           item_valid,
    output logic                                item_stall,
    input  wire logic [knap_pkg::VALUE_W-1:0]   item_value,
    input  wire logic [knap_pkg::WEIGHT_W-1:0]  item_weight,
    input  wire logic                           last_item,
    output logic                                result_valid,
    input  wire logic                           result_stall,
    output logic      [knap_pkg::ENTRY_W-1:0]   best_value,
    output logic                                saturated,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [knap_pkg::CAP_W-1:0]     cfg_data
);

    knap_pkg::ctrl_t               ctl;
    logic [knap_pkg::CAP_W-1:0]    capacity_reg, capacity_next;
    logic [knap_pkg::VALUE_W-1:0]  value_reg, value_next;
    logic                          sat_reg, sat_next;
    logic                          res_valid_reg, res_valid_next;
    logic [knap_pkg::ENTRY_W-1:0]  res_value_reg, res_value_next;
    logic                          res_sat_reg, res_sat_next;
    logic                          slot_free;
    logic [knap_pkg::ENTRY_W-1:0]  rd_data_a, rd_data_b;
    logic [knap_pkg::ENTRY_W-1:0]  upd_entry;
    logic                          upd_sat;
    logic [knap_pkg::ENTRY_W-1:0]  wr_data;

    // The output register can take a new result when empty or being drained.
    assign slot_free = !res_valid_reg || !result_stall;
    assign cfg_ready = 1'b1;

    knap_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_weight (item_weight),
        .last_item   (last_item),
        .capacity    (capacity_reg),
        .slot_free   (slot_free),
        .item_stall  (item_stall),
        .ctl         (ctl)
    );

    knap_table u_table (
        .clk       (clk),
        .wr_en     (ctl.wr_en),
        .wr_addr   (ctl.wr_addr),
        .wr_data   (wr_data),
        .rd_en     (ctl.rd_en),
        .rd_addr_a (ctl.rd_addr_a),
        .rd_addr_b (ctl.rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    knap_update u_update (
        .old_entry  (rd_data_a),
        .src_entry  (rd_data_b),
        .item_value (value_reg),
        .new_entry  (upd_entry),
        .sat        (upd_sat)
    );

    // Clearing writes zero; otherwise the update result goes back in place.
    assign wr_data = ctl.wr_zero ? '0 : upd_entry;

    always_comb
    begin
        capacity_next  = cfg_valid ? cfg_data : capacity_reg;
        value_next     = ctl.accept ? item_value : value_reg;

        // The saturation flag collects over a set and restarts once reported.
        sat_next = sat_reg;
        if (ctl.load_result)
        begin
            sat_next = 1'b0;
        end
        else if (ctl.upd_valid && upd_sat)
        begin
            sat_next = 1'b1;
        end

        res_valid_next = res_valid_reg;
        res_value_next = res_value_reg;
        res_sat_next   = res_sat_reg;
        if (ctl.load_result)
        begin
            res_valid_next = 1'b1;
            res_value_next = rd_data_a;
            res_sat_next   = sat_reg;
        end
        else if (res_valid_reg && !result_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= '0;
            sat_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            capacity_reg  <= capacity_next;
            sat_reg       <= sat_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg     <= value_next;
        res_value_reg <= res_value_next;
        res_sat_reg   <= res_sat_next;
    end

    assign result_valid = res_valid_reg;
    assign best_value   = res_value_reg;
    assign saturated    = res_sat_reg;

endmodule

`default_nettype wire

/* hw/rtl/knap_checker.sv */
// Port-level checks for the knapsack core, bound to its top level.
`default_nettype none

module knap_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           item_valid,
    input wire logic                           item_stall,
    input wire logic                           last_item,
    input wire logic                           result_valid,
    input wire logic                           result_stall,
    input wire logic [knap_pkg::ENTRY_W-1:0]   best_value,
    input wire logic                           saturated
);

    // A stalled result holds until it is taken.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=>
            result_valid && $stable(best_value) && $stable(saturated))
        else $error("stalled result changed");

    // A last item always starts a pass that holds item_stall high.
    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && last_item |=> item_stall)
        else $error("block took a request right after a last item");

    // A new result appears while the table is being cleared.
    a_result_clear: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> item_stall ##1 item_stall)
        else $error("result appeared without a clearing pass");

endmodule

bind knapsack_by_weight_dp_core knap_checker u_knap_checker (.*);

`default_nettype wire
